[sv/bse_pkg.sv]
`default_nettype none

package bse_pkg;

    // bitmap geometry
    localparam int MAX_WORDS = 64;
    localparam int WORD_W    = 64;
    localparam int ADDR_W    = $clog2(MAX_WORDS);
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int CURSOR_W  = 13;
    localparam int CFG_W     = 7;

    // request opcodes
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_TEST   = 3'd2;
    localparam logic [2:0] OP_IRESET = 3'd3;
    localparam logic [2:0] OP_INEXT  = 3'd4;

    // response status codes
    localparam logic [3:0] STAT_CREATED  = 4'd0;
    localparam logic [3:0] STAT_MERGED   = 4'd1;
    localparam logic [3:0] STAT_REMOVED  = 4'd2;
    localparam logic [3:0] STAT_NOTFOUND = 4'd3;
    localparam logic [3:0] STAT_RANGE    = 4'd4;
    localparam logic [3:0] STAT_TESTED   = 4'd5;
    localparam logic [3:0] STAT_FOUND    = 4'd6;
    localparam logic [3:0] STAT_END      = 4'd7;
    localparam logic [3:0] STAT_RESET    = 4'd8;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [15:0] element;
    } bse_req_t;

    typedef struct packed {
        logic [3:0]  status;
        logic        present;
        logic [11:0] found_index;
    } bse_rsp_t;

    // access to the word store
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
    } bse_mem_req_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } bse_state_t;

    // index of the lowest set bit, binary search over halves
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] lo_mask;
        logic [BIT_W-1:0]  idx;
        v   = w;
        idx = '0;
        for (int l = BIT_W - 1; l >= 0; l--)
        begin
            lo_mask = (WORD_W'(1) << (1 << l)) - WORD_W'(1);
            if ((v & lo_mask) == '0)
            begin
                idx[l] = 1'b1;
                v      = v >> (1 << l);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

[sv/bitmap_set_engine.sv]
`default_nettype none

// Bit set engine over up to 64 words of 64 bits (element indexes 0..4095).
// Request channel req (req_valid / req_stall) carries opcode and element;
// response channel rsp (rsp_valid / rsp_stall) returns exactly one beat per
// request: status, present and found_index.
// Config channel cfg (cfg_valid / cfg_ready / cfg_data) writes words_in_use;
// cfg_ready is always high, write only while no request is outstanding.
// Every request issues its word read in the request cycle; insert and delete
// write the modified word back in the execute state, after the registered
// word read. Iterator next also skips every further all-zero word it meets:
// the scan reads one word per cycle from the single read port of the word
// store.
// One request is in flight at a time; req_stall is high while it executes.
// A finished response sits in the output register, so the next request is
// taken while the consumer stalls; the engine holds its result in the
// execute cycle only if the output register is still occupied and stalled.
// Reset clears all words at once (per-word written flags), zeroes the
// iterator cursor and sets words_in_use to 64.

module bitmap_set_engine (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    req_valid,
    output logic                         req_stall,
    input  wire bse_pkg::bse_req_t       req,
    output logic                         rsp_valid,
    input  wire logic                    rsp_stall,
    output bse_pkg::bse_rsp_t            rsp,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [bse_pkg::CFG_W-1:0] cfg_data
);
    import bse_pkg::*;

    bse_state_t          state_reg, state_next;
    logic [2:0]          op_reg;
    logic [15:0]         elem_reg;
    logic [CURSOR_W-1:0] cursor_reg, cursor_next;
    logic [CFG_W-1:0]    words_reg;
    logic                rsp_valid_reg, rsp_valid_next;
    bse_rsp_t            rsp_reg, rsp_next;
    bse_mem_req_t        mem_req;
    logic [WORD_W-1:0]   rd_word;

    logic                req_beat;
    logic                out_free;
    logic [CFG_W-1:0]    active;
    logic [CURSOR_W-1:0] limit;
    logic                elem_ok;
    logic [WORD_W-1:0]   bit_mask;
    logic [WORD_W-1:0]   scan_word;
    logic [ADDR_W:0]     next_word;
    logic [CURSOR_W-1:0] next_pos;
    logic [CURSOR_W-1:0] found_pos;

    bse_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .mem_req (mem_req),
        .rd_word (rd_word)
    );

    assign req_beat  = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // range of the words in use
    assign active  = (words_reg > CFG_W'(MAX_WORDS)) ? CFG_W'(MAX_WORDS) : words_reg;
    assign limit   = {active, {BIT_W{1'b0}}};
    assign elem_ok = !elem_reg[15] && (elem_reg[14:6] < {2'b00, active});

    // bit and scan helpers
    assign bit_mask  = WORD_W'(1) << elem_reg[BIT_W-1:0];
    assign scan_word = rd_word & ({WORD_W{1'b1}} << cursor_reg[BIT_W-1:0]);
    assign next_word = {1'b0, cursor_reg[BIT_W+ADDR_W-1:BIT_W]} + (ADDR_W+1)'(1);
    assign next_pos  = {next_word, {BIT_W{1'b0}}};
    assign found_pos = {1'b0, cursor_reg[BIT_W+ADDR_W-1:BIT_W], lowest_set(scan_word)};

    // control state and config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= '0;
            words_reg     <= CFG_W'(MAX_WORDS);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                words_reg <= cfg_data;
            end
        end
    end

    // request and response payload
    always_ff @(posedge clk)
    begin
        if (req_beat)
        begin
            op_reg   <= req.opcode;
            elem_reg <= req.element;
        end
        rsp_reg <= rsp_next;
    end

    // sequencer: read, then modify and write back, answer from the word, or scan
    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        mem_req        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next    = S_EXEC;
                    mem_req.rd_en = 1'b1;
                    if (req.opcode == OP_INEXT)
                    begin
                        mem_req.rd_addr = cursor_reg[BIT_W+ADDR_W-1:BIT_W];
                    end
                    else
                    begin
                        mem_req.rd_addr = req.element[BIT_W+ADDR_W-1:BIT_W];
                    end
                end
            end
            S_EXEC:
            begin
                if (op_reg == OP_INEXT && cursor_reg < limit && scan_word == '0
                    && next_pos < limit)
                begin
                    // skip an empty word and fetch the next one
                    cursor_next     = next_pos;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = next_word[ADDR_W-1:0];
                end
                else if (out_free)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            if (elem_ok)
                            begin
                                rsp_next.status = ((rd_word & bit_mask) != '0) ?
                                                  STAT_MERGED : STAT_CREATED;
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = elem_reg[BIT_W+ADDR_W-1:BIT_W];
                                mem_req.wr_data = rd_word | bit_mask;
                            end
                            else
                            begin
                                rsp_next.status = STAT_RANGE;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (elem_ok)
                            begin
                                rsp_next.status = ((rd_word & bit_mask) != '0) ?
                                                  STAT_REMOVED : STAT_NOTFOUND;
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = elem_reg[BIT_W+ADDR_W-1:BIT_W];
                                mem_req.wr_data = rd_word & ~bit_mask;
                            end
                            else
                            begin
                                rsp_next.status = STAT_RANGE;
                            end
                        end
                        OP_TEST:
                        begin
                            rsp_next.status  = STAT_TESTED;
                            rsp_next.present = elem_ok && ((rd_word & bit_mask) != '0);
                        end
                        OP_IRESET:
                        begin
                            rsp_next.status = STAT_RESET;
                            cursor_next     = '0;
                        end
                        OP_INEXT:
                        begin
                            if (cursor_reg < limit && scan_word != '0)
                            begin
                                rsp_next.status      = STAT_FOUND;
                                rsp_next.found_index = found_pos[11:0];
                                cursor_next          = found_pos + CURSOR_W'(1);
                            end
                            else
                            begin
                                rsp_next.status = STAT_END;
                                cursor_next     = limit;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = STAT_RANGE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // the store never sees a read and a write in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.rd_en && mem_req.wr_en))
        else $error("word store read and write collide");

    // an accepted request always moves the sequencer into execution
    assert property (@(posedge clk) disable iff (!rst_n)
        req_beat |=> (state_reg == S_EXEC))
        else $error("accepted request not executed");

    // a response is produced only when leaving execution
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_next && !(rsp_valid_reg && rsp_stall)) |-> (state_reg == S_EXEC))
        else $error("response loaded outside execution");

    // the cursor never runs past the full bitmap
    assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= CURSOR_W'(MAX_WORDS * WORD_W))
        else $error("iterator cursor out of bounds");

endmodule

`default_nettype wire

[sv/bse_store.sv]
`default_nettype none

module bse_store (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire bse_pkg::bse_mem_req_t        mem_req,
    output logic [bse_pkg::WORD_W-1:0]        rd_word
);
    import bse_pkg::*;

    logic [WORD_W-1:0]    mem [MAX_WORDS];
    logic [MAX_WORDS-1:0] valid_reg;
    logic [WORD_W-1:0]    rd_data_reg;
    logic                 rd_vld_reg;

    // word array, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data_reg <= mem[mem_req.rd_addr];
        end
    end

    // per-word written flags, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (mem_req.wr_en)
            begin
                valid_reg[mem_req.wr_addr] <= 1'b1;
            end
            if (mem_req.rd_en)
            begin
                rd_vld_reg <= valid_reg[mem_req.rd_addr];
            end
        end
    end

    // a word never written reads as zero
    assign rd_word = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire
